>>> hw/rtl/cdq_pkg.sv
// Package: shared types and codes for the circular deque.
`timescale 1ns / 1ps

package cdq_pkg;

    // Fixed field widths of the channels and the configuration register
    localparam int DATA_W          = 32;
    localparam int RING_LEN_W      = 5;
    localparam logic [RING_LEN_W-1:0] RING_LEN_RESET = 5'd16;

    // Operation codes carried by a request
    typedef enum logic [1:0] {
        OP_PUSH_FRONT = 2'd0,
        OP_PUSH_REAR  = 2'd1,
        OP_POP_FRONT  = 2'd2,
        OP_POP_REAR   = 2'd3
    } op_t;

    // Result status codes
    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } status_t;

    // Controller to datapath command group
    typedef struct packed {
        logic exec;     // perform the accepted request this cycle
    } cmd_t;

endpackage

>>> hw/rtl/cdq_req_if.sv
// Interface: request channel carrying the operation and push value.
`timescale 1ns / 1ps

interface cdq_req_if;
    import cdq_pkg::*;

    logic                      valid;
    logic                      ready;
    op_t                       op;
    logic signed [DATA_W-1:0]  push_value;

    modport source (output valid, output op, output push_value, input ready);
    modport sink   (input valid, input op, input push_value, output ready);
endinterface

>>> hw/rtl/cdq_rsp_if.sv
// Interface: response channel carrying the popped value and status.
`timescale 1ns / 1ps

interface cdq_rsp_if;
    import cdq_pkg::*;

    logic                      valid;
    logic                      ready;
    logic signed [DATA_W-1:0]  pop_value;
    status_t                   status;

    modport source (output valid, output pop_value, output status, input ready);
    modport sink   (input valid, input pop_value, input status, output ready);
endinterface

>>> hw/rtl/cdq_ctrl.sv
// Controller: request/response handshake sequencing for the deque.
`timescale 1ns / 1ps

module cdq_ctrl (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         req_valid,
    output logic         req_ready,
    output logic         rsp_valid,
    input  logic         rsp_ready,
    output cdq_pkg::cmd_t cmd
);
    import cdq_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_RESP = 2'b10
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   accept;

    // A new request is taken when no response waits or the waiting one leaves now
    assign req_ready = (state_reg == S_IDLE) || ((state_reg == S_RESP) && rsp_ready);
    assign rsp_valid = (state_reg == S_RESP);
    assign accept    = req_valid && req_ready;
    assign cmd.exec  = accept;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_RESP;
                end
            end
            S_RESP:
            begin
                if (accept)
                begin
                    state_next = S_RESP;
                end
                else if (rsp_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end
endmodule

>>> hw/rtl/cdq_datapath.sv
// Datapath: slot memory, front/rear indices, ring length and result registers.
`timescale 1ns / 1ps

module cdq_datapath #(
    parameter int MAX_SLOTS  = 16,
    parameter int VALUE_BITS = 32
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic [cdq_pkg::RING_LEN_W-1:0]     cfg_wdata,
    input  cdq_pkg::cmd_t                      cmd,
    input  cdq_pkg::op_t                       op,
    input  logic signed [cdq_pkg::DATA_W-1:0]  push_value,
    output logic signed [cdq_pkg::DATA_W-1:0]  pop_value,
    output cdq_pkg::status_t                   status
);
    import cdq_pkg::*;

    localparam int IDX_W = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
    localparam int LEN_W = IDX_W + 1;

    logic [RING_LEN_W-1:0]  ring_length_reg;
    logic [IDX_W-1:0]       front_reg;
    logic [IDX_W-1:0]       front_next;
    logic [IDX_W-1:0]       rear_reg;
    logic [IDX_W-1:0]       rear_next;
    logic [VALUE_BITS-1:0]  slot_mem [MAX_SLOTS];
    logic [VALUE_BITS-1:0]  rd_data_reg;
    logic                   popped_reg;
    status_t                status_reg;

    logic [LEN_W-1:0]       eff_len;
    logic [IDX_W-1:0]       last_idx;
    logic [LEN_W-1:0]       front_inc;
    logic [LEN_W-1:0]       rear_inc;
    logic [IDX_W-1:0]       front_up;
    logic [IDX_W-1:0]       front_down;
    logic [IDX_W-1:0]       rear_up;
    logic [IDX_W-1:0]       rear_down;
    logic                   is_empty;
    logic                   is_full;
    logic                   wr_en;
    logic [IDX_W-1:0]       wr_addr;
    logic [IDX_W-1:0]       rd_addr;
    logic                   do_pop;
    status_t                status_next;
    logic [63:0]            push_wide;
    logic [63:0]            pop_wide;

    // Effective ring length, clamped to 2..MAX_SLOTS
    always_comb
    begin
        if (32'(ring_length_reg) > MAX_SLOTS)
        begin
            eff_len = LEN_W'(MAX_SLOTS);
        end
        else if (ring_length_reg < 5'd2)
        begin
            eff_len = LEN_W'(2);
        end
        else
        begin
            eff_len = LEN_W'(ring_length_reg);
        end
    end

    assign last_idx = IDX_W'(eff_len - LEN_W'(1));

    // Index steps with wrap compare
    assign front_inc  = {1'b0, front_reg} + LEN_W'(1);
    assign rear_inc   = {1'b0, rear_reg} + LEN_W'(1);
    assign front_up   = (front_inc >= eff_len) ? '0 : front_inc[IDX_W-1:0];
    assign rear_up    = (rear_inc >= eff_len) ? '0 : rear_inc[IDX_W-1:0];
    assign front_down = (front_reg == '0) ? last_idx : front_reg - IDX_W'(1);
    assign rear_down  = (rear_reg == '0) ? last_idx : rear_reg - IDX_W'(1);

    assign is_empty = (front_reg == rear_reg);
    assign is_full  = (rear_up == front_reg);

    // Operation decode
    always_comb
    begin
        front_next  = front_reg;
        rear_next   = rear_reg;
        wr_en       = 1'b0;
        wr_addr     = rear_up;
        rd_addr     = rear_reg;
        do_pop      = 1'b0;
        status_next = ST_OK;
        case (op)
            OP_PUSH_FRONT:
            begin
                wr_addr = front_reg;
                if (is_full)
                begin
                    status_next = ST_FULL;
                end
                else
                begin
                    wr_en      = 1'b1;
                    front_next = front_down;
                end
            end
            OP_PUSH_REAR:
            begin
                if (is_full)
                begin
                    status_next = ST_FULL;
                end
                else
                begin
                    wr_en     = 1'b1;
                    rear_next = rear_up;
                end
            end
            OP_POP_FRONT:
            begin
                rd_addr = front_up;
                if (is_empty)
                begin
                    status_next = ST_EMPTY;
                end
                else
                begin
                    do_pop     = 1'b1;
                    front_next = front_up;
                end
            end
            default:
            begin
                if (is_empty)
                begin
                    status_next = ST_EMPTY;
                end
                else
                begin
                    do_pop    = 1'b1;
                    rear_next = rear_down;
                end
            end
        endcase
    end

    // Ring length register and indices; a length write empties the queue
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ring_length_reg <= RING_LEN_RESET;
            front_reg       <= '0;
            rear_reg        <= '0;
        end
        else if (cfg_we)
        begin
            ring_length_reg <= cfg_wdata;
            front_reg       <= '0;
            rear_reg        <= '0;
        end
        else if (cmd.exec)
        begin
            front_reg <= front_next;
            rear_reg  <= rear_next;
        end
    end

    // Push data keeps the low VALUE_BITS bits
    assign push_wide = {32'b0, push_value};

    // Slot memory: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (cmd.exec && wr_en)
        begin
            slot_mem[wr_addr] <= push_wide[VALUE_BITS-1:0];
        end
        if (cmd.exec)
        begin
            rd_data_reg <= slot_mem[rd_addr];
        end
    end

    // Result registers
    always_ff @(posedge clk)
    begin
        if (cmd.exec)
        begin
            popped_reg <= do_pop;
            status_reg <= status_next;
        end
    end

    // Sign-extend the stored value to the response width
    assign pop_wide  = 64'($signed(rd_data_reg));
    assign pop_value = popped_reg ? $signed(pop_wide[DATA_W-1:0]) : '1;
    assign status    = status_reg;
endmodule

>>> hw/rtl/circular_deque.sv
// Top level: double-ended queue in a ring of slots.
//
// Usage:
//   req_ch (sink) takes one request: op (push front, push rear, pop front,
//   pop rear) and push_value. rsp_ch (source) returns one response per
//   request: pop_value (popped value, or -1 for pushes and refused pops)
//   and status (ok, full, empty).
//   cfg_we/cfg_wdata write ring_length (2..MAX_SLOTS slots, capacity one
//   less); a write also empties the queue. Write only while idle.
// Timing: the response is valid in the cycle after the request is accepted;
//   the controller's state register and the slot memory's registered read port set it.
// Throughput: one request per cycle while rsp_ch.ready stays high; the
//   response register frees as it is taken, so a new request enters in
//   the same cycle.
// Stall: while a response waits with rsp_ch.ready low, req_ch.ready is
//   low and the response holds.
// Reset: indices cleared (queue empty), ring_length = 16; no clearing pass.
`timescale 1ns / 1ps

module circular_deque #(
    parameter int MAX_SLOTS  = 16,
    parameter int VALUE_BITS = 32
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [cdq_pkg::RING_LEN_W-1:0]  cfg_wdata,
    cdq_req_if.sink                         req_ch,
    cdq_rsp_if.source                       rsp_ch
);
    import cdq_pkg::*;

    cmd_t cmd;

    // Handshake sequencing
    cdq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_ch.valid),
        .req_ready (req_ch.ready),
        .rsp_valid (rsp_ch.valid),
        .rsp_ready (rsp_ch.ready),
        .cmd       (cmd)
    );

    // Storage and index logic
    cdq_datapath #(
        .MAX_SLOTS  (MAX_SLOTS),
        .VALUE_BITS (VALUE_BITS)
    ) u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .cmd        (cmd),
        .op         (req_ch.op),
        .push_value (req_ch.push_value),
        .pop_value  (rsp_ch.pop_value),
        .status     (rsp_ch.status)
    );

    // An accepted request yields a response in the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        (req_ch.valid && req_ch.ready) |=> rsp_ch.valid)
    else $error("response missing after accepted request");

    // A refused operation reports -1
    assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_ch.valid && (rsp_ch.status == ST_FULL || rsp_ch.status == ST_EMPTY))
            |-> (rsp_ch.pop_value == -32'sd1))
    else $error("refused operation returned a value");

    // A stalled response blocks new requests
    assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_ch.valid && !rsp_ch.ready) |-> !req_ch.ready)
    else $error("request taken while response stalled");
endmodule
